### rtl/pia_pkg.sv
// ----------------------------------------------------------------------------
// Palette index assigner package
// Shared sizes, the search word type and the grey ramp function.
// ----------------------------------------------------------------------------
package pia_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int COLOR_W       = 32;
  localparam int INDEX_OUT_W   = 8;

  typedef struct packed {
    logic               valid;
    logic               done;
    logic               is_new;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
  } probe_t;

  function automatic logic [COLOR_W-1:0] gray_word(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    c = 8'(idx);
    gray_word = {8'hFF, c, c, c};
  endfunction

endpackage

### rtl/pia_cell.sv
// ----------------------------------------------------------------------------
// Palette cell
// Holds one palette entry, compares the passing search word with it and
// appends the colour when the search reaches the first free entry.
// ----------------------------------------------------------------------------
module pia_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        load_gray,
  input  logic [pia_pkg::IDX_W-1:0]   cell_index,
  input  logic [pia_pkg::CNT_W-1:0]   entry_count,
  input  pia_pkg::probe_t             probe_in,
  output pia_pkg::probe_t             probe_out
);
  import pia_pkg::*;

  logic [COLOR_W-1:0] entry;
  logic               live;
  logic               hit;
  logic               append;
  probe_t             probe_next;

  assign live   = probe_in.valid && !probe_in.done;
  assign hit    = live && (CNT_W'(cell_index) < entry_count) && (entry == probe_in.color);
  assign append = live && (CNT_W'(cell_index) == entry_count);

  always_comb begin
    probe_next = probe_in;
    if (hit || append) begin
      probe_next.done  = 1'b1;
      probe_next.index = cell_index;
    end
    if (append) begin
      probe_next.is_new = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_gray) begin
      entry <= gray_word(cell_index);
    end else if (advance && append) begin
      entry <= probe_in.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else if (advance) begin
      probe_out.valid <= probe_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      probe_out.done   <= probe_next.done;
      probe_out.is_new <= probe_next.is_new;
      probe_out.index  <= probe_next.index;
      probe_out.color  <= probe_next.color;
    end
  end

endmodule

### rtl/palette_index_assigner.sv
// ----------------------------------------------------------------------------
// Palette index assigner
// Gives each 32-bit ARGB pixel word an index into a palette built in order.
// ----------------------------------------------------------------------------
// The palette lives in a row of PALETTE_DEPTH cells, one entry per cell, and
// a pixel is looked up by a search word that moves one cell per clock while the
// output is not stalled; the first matching cell gives the index, and the first
// free cell appends the colour. One pixel is searched at a time: the next word
// is accepted only once the result leaves the last cell and is registered on
// the output. A start_image flag empties the palette, or with preload_gray set
// fills every cell with its grey level in the same cycle. When no cell matches
// and the palette is full, the result carries overflow and index 0.
module palette_index_assigner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // preload_gray
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,      // [31:0] pixel_color
  input  logic        s_tuser,      // [0] start_image
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,      // [7:0] palette_index
  output logic [1:0]  m_tuser       // [0] is_new_entry, [1] overflow
);
  import pia_pkg::*;

  logic               preload_gray;
  logic               busy;
  logic [CNT_W-1:0]   entry_count;
  logic               accept;
  logic               advance;
  logic               load_gray;
  logic               result_take;
  probe_t             head;
  probe_t             chain [PALETTE_DEPTH+1];
  probe_t             tail;

  assign accept      = s_tvalid && s_tready;
  assign s_tready    = !busy;
  assign load_gray   = accept && s_tuser && preload_gray;
  assign tail        = chain[PALETTE_DEPTH];
  assign advance     = !(tail.valid && m_tvalid && !m_tready);
  assign result_take = tail.valid && advance;
  assign chain[0]    = head;

  genvar i;
  generate
    for (i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      pia_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .advance     (advance),
        .load_gray   (load_gray),
        .cell_index  (IDX_W'(i)),
        .entry_count (entry_count),
        .probe_in    (chain[i]),
        .probe_out   (chain[i+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      preload_gray <= 1'b0;
    end else if (cfg_wr_en) begin
      preload_gray <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      entry_count <= '0;
      head.valid  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        busy       <= 1'b1;
        head.valid <= 1'b1;
      end else if (result_take) begin
        busy <= 1'b0;
      end else if (advance) begin
        head.valid <= 1'b0;
      end

      if (accept && s_tuser) begin
        entry_count <= preload_gray ? CNT_W'(PALETTE_DEPTH) : '0;
      end else if (result_take && tail.is_new) begin
        entry_count <= CNT_W'(entry_count + 1'b1);
      end

      if (result_take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head.done   <= 1'b0;
      head.is_new <= 1'b0;
      head.index  <= '0;
      head.color  <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (result_take) begin
      m_tdata    <= tail.done ? INDEX_OUT_W'(tail.index) : '0;
      m_tuser[0] <= tail.is_new;
      m_tuser[1] <= !tail.done;
    end
  end

endmodule
